>>> hdl/rotor_substitution_unit_assert.svh
// assertion macros shared by the rotor substitution checker
`ifndef ROTOR_SUBSTITUTION_UNIT_ASSERT_SVH
`define ROTOR_SUBSTITUTION_UNIT_ASSERT_SVH

// cond at one edge implies expr at the next, outside reset
`define RSU_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("rotor substitution check failed");

// expr holds at the edge after reset was seen low
`define RSU_ASSERT_AFTER_RESET(label, expr) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (expr)) \
        else $error("rotor substitution reset check failed");

`endif

>>> hdl/rsu_pkg.sv
// shared types, constants and helpers of the rotor substitution unit
`timescale 1ns / 1ps
package rsu_pkg;

    // alphabet size of the rotor
    localparam int ALPHABET_LEN = 26;

    // field widths
    localparam int SYM_W  = 5;
    localparam int CHAR_W = 8;
    localparam int OP_W   = 2;
    localparam int SUM_W  = SYM_W + 1;
    localparam int ADDR_W = (ALPHABET_LEN > 1) ? $clog2(ALPHABET_LEN) : 1;
    localparam int CNT_W  = $clog2(ALPHABET_LEN + 1);
    localparam int TDATA_W = 24;

    localparam logic [SUM_W-1:0] LEN_SUM = SUM_W'(ALPHABET_LEN);
    localparam logic [CNT_W-1:0] LEN_CNT = CNT_W'(ALPHABET_LEN);

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_FWD  = 2'd1;
    localparam logic [OP_W-1:0] OP_BWD  = 2'd2;

    // ascii constants
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'd32;

    // residue table for every 5-bit value
    typedef logic [(1 << SYM_W)-1:0][SYM_W-1:0] t_mod_tab;

    function automatic t_mod_tab build_mod_tab();
        t_mod_tab tab;
        for (int i = 0; i < (1 << SYM_W); i++) begin
            tab[i] = SYM_W'(i % ALPHABET_LEN);
        end
        return tab;
    endfunction

    localparam t_mod_tab MOD_TAB = build_mod_tab();

    function automatic logic [SYM_W-1:0] mod_len(input logic [SYM_W-1:0] x);
        return MOD_TAB[x];
    endfunction

    // one conditional subtract, input below twice the alphabet size
    function automatic logic [SYM_W-1:0] reduce_once(input logic [SUM_W-1:0] x);
        logic [SUM_W-1:0] d;
        d = (x >= LEN_SUM) ? (x - LEN_SUM) : x;
        return d[SYM_W-1:0];
    endfunction

    // controller to datapath
    typedef struct packed {
        logic load;      // load item accepted
        logic capture;   // pass item accepted
        logic prep;      // build table index and reverse shift
        logic fwd_rd;    // read table at shifted index
        logic fwd_res;   // forward result from read data
        logic search;    // backward search step
        logic bwd_done;  // backward result from search outcome
        logic out_load;  // move result into output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_letter;
        logic cnt_end;
        logic hit;
        logic rd_pending;
    } t_sts;

endpackage

>>> hdl/rsu_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module rsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                         i_wdata,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/rsu_ctrl.sv
// controller state machine of the rotor substitution unit
`timescale 1ns / 1ps
module rsu_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [rsu_pkg::OP_W-1:0] i_op,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    input  rsu_pkg::t_sts            i_sts,
    output rsu_pkg::t_cmd            o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_FWD_RD,
        S_FWD_RES,
        S_SEARCH,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_is_bwd, n_is_bwd;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_search_end;

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_search_end = i_sts.hit || (i_sts.cnt_end && !i_sts.rd_pending);

    always_comb begin
        n_state     = r_state;
        n_is_bwd    = r_is_bwd;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == rsu_pkg::OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else if (i_op == rsu_pkg::OP_FWD || i_op == rsu_pkg::OP_BWD) begin
                        o_cmd.capture = 1'b1;
                        n_is_bwd      = (i_op == rsu_pkg::OP_BWD);
                        n_state       = S_PREP;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (!i_sts.is_letter) begin
                    n_state = S_FINISH;
                end else if (r_is_bwd) begin
                    n_state = S_SEARCH;
                end else begin
                    n_state = S_FWD_RD;
                end
            end
            S_FWD_RD: begin
                o_cmd.fwd_rd = 1'b1;
                n_state      = S_FWD_RES;
            end
            S_FWD_RES: begin
                o_cmd.fwd_res = 1'b1;
                n_state       = S_FINISH;
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (w_search_end) begin
                    o_cmd.bwd_done = 1'b1;
                    n_state        = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_is_bwd    <= n_is_bwd;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/rsu_datapath.sv
// datapath of the rotor substitution unit: shifts, table access, search, result
`timescale 1ns / 1ps
module rsu_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rsu_pkg::t_cmd               i_cmd,
    output rsu_pkg::t_sts               o_sts,
    input  logic                        i_cfg_valid,
    input  logic [rsu_pkg::SYM_W-1:0]   i_cfg_data,
    input  logic [rsu_pkg::SYM_W-1:0]   i_entry_index,
    input  logic [rsu_pkg::SYM_W-1:0]   i_wiring_letter,
    input  logic [rsu_pkg::CHAR_W-1:0]  i_char_in,
    input  logic [rsu_pkg::SYM_W-1:0]   i_rotor_position,
    output logic [rsu_pkg::CHAR_W-1:0]  o_char_out
);

    localparam int SYM_W  = rsu_pkg::SYM_W;
    localparam int SUM_W  = rsu_pkg::SUM_W;
    localparam int CHAR_W = rsu_pkg::CHAR_W;
    localparam int ADDR_W = rsu_pkg::ADDR_W;
    localparam int CNT_W  = rsu_pkg::CNT_W;

    logic [SYM_W-1:0]  r_ring;
    logic [CHAR_W-1:0] r_char;
    logic              r_is_letter;
    logic              r_lower;
    logic [SYM_W-1:0]  r_letter;
    logic [SYM_W-1:0]  r_shift;
    logic [SYM_W-1:0]  r_idx;
    logic [SYM_W-1:0]  r_nshift;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_rd_idx;
    logic              r_rd_vld;
    logic [SYM_W-1:0]  r_res;
    logic [CHAR_W-1:0] r_out_data;

    logic              w_is_lower;
    logic              w_is_upper;
    logic [CHAR_W-1:0] w_letter8;
    logic [SYM_W-1:0]  w_shift;
    logic              w_cnt_end;
    logic              w_search_rd;
    logic              w_hit;
    logic [CNT_W-1:0]  w_found;
    logic              w_we;
    logic              w_re;
    logic [ADDR_W-1:0] w_addr;
    logic [SYM_W-1:0]  w_rdata;

    // letter classification on the incoming byte
    assign w_is_lower = (i_char_in >= rsu_pkg::ASCII_LOWER_A) &&
                        (i_char_in <= rsu_pkg::ASCII_LOWER_Z);
    assign w_is_upper = (i_char_in >= rsu_pkg::ASCII_UPPER_A) &&
                        (i_char_in <= rsu_pkg::ASCII_UPPER_Z);
    assign w_letter8  = i_char_in - (w_is_lower ? rsu_pkg::ASCII_LOWER_A
                                                : rsu_pkg::ASCII_UPPER_A);

    // position minus ring setting, modulo alphabet
    assign w_shift = rsu_pkg::reduce_once(SUM_W'(rsu_pkg::mod_len(i_rotor_position))
                                          + rsu_pkg::LEN_SUM
                                          - SUM_W'(rsu_pkg::mod_len(r_ring)));

    assign w_cnt_end   = (r_cnt == rsu_pkg::LEN_CNT);
    assign w_search_rd = i_cmd.search && !w_cnt_end;
    assign w_hit       = r_rd_vld && (w_rdata == r_idx);
    assign w_found     = w_hit ? r_rd_idx : rsu_pkg::LEN_CNT;

    // table port: loads from the input, reads at shifted index or search count
    assign w_we = i_cmd.load && (SUM_W'(i_entry_index) < rsu_pkg::LEN_SUM);
    assign w_re = i_cmd.fwd_rd || w_search_rd;

    always_comb begin
        if (i_cmd.load) begin
            w_addr = i_entry_index[ADDR_W-1:0];
        end else if (i_cmd.fwd_rd) begin
            w_addr = r_idx[ADDR_W-1:0];
        end else begin
            w_addr = r_cnt[ADDR_W-1:0];
        end
    end

    rsu_ram #(
        .WIDTH (SYM_W),
        .DEPTH (rsu_pkg::ALPHABET_LEN)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (i_wiring_letter),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_ring <= i_cfg_data;
            end
            r_rd_vld <= w_search_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_char      <= i_char_in;
            r_is_letter <= w_is_lower || w_is_upper;
            r_lower     <= w_is_lower;
            r_letter    <= rsu_pkg::mod_len(w_letter8[SYM_W-1:0]);
            r_shift     <= w_shift;
        end
        if (i_cmd.prep) begin
            r_idx    <= rsu_pkg::reduce_once(SUM_W'(r_letter) + SUM_W'(r_shift));
            r_nshift <= rsu_pkg::reduce_once(rsu_pkg::LEN_SUM - SUM_W'(r_shift));
            r_cnt    <= '0;
        end else if (w_search_rd) begin
            r_cnt <= r_cnt + 1'b1;
        end
        r_rd_idx <= r_cnt;
        if (i_cmd.fwd_res) begin
            r_res <= rsu_pkg::reduce_once(SUM_W'(rsu_pkg::mod_len(w_rdata))
                                          + SUM_W'(r_nshift));
        end else if (i_cmd.bwd_done) begin
            r_res <= rsu_pkg::reduce_once(SUM_W'(w_found) + SUM_W'(r_nshift));
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_is_letter
                ? (CHAR_W'(r_res) + rsu_pkg::ASCII_UPPER_A
                   + (r_lower ? rsu_pkg::CASE_OFFSET : '0))
                : r_char;
        end
    end

    assign o_sts.is_letter  = r_is_letter;
    assign o_sts.cnt_end    = w_cnt_end;
    assign o_sts.hit        = w_hit;
    assign o_sts.rd_pending = r_rd_vld;
    assign o_char_out       = r_out_data;

endmodule

>>> hdl/rotor_substitution_unit.sv
// top level of the rotor substitution unit
// load item: writes the table entry at entry_index if in range, no result; a non-letter byte
// goes through prep and finish; forward pass: prep, table read, forward result, finish
// backward pass: prep, a table search up to a match or the last entry, finish; the search
//   reads one wiring entry per cycle from a single-port ram; next item taken after finish
// reset: synchronous, active low; clears controller state, output valid and ring setting
// the wiring table is not cleared and must be loaded before any pass reads it
`timescale 1ns / 1ps
module rotor_substitution_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [4:0] entry_index, [9:5] wiring_letter, [17:10] char_in,
    // [22:18] rotor_position, [23] zero fill
    input  logic [rsu_pkg::TDATA_W-1:0]   s_axis_tdata,
    // [1:0] operation
    input  logic [rsu_pkg::OP_W-1:0]      s_axis_tuser,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] char_out
    output logic [rsu_pkg::CHAR_W-1:0]    m_axis_tdata,
    // ring setting write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rsu_pkg::SYM_W-1:0]     i_cfg_data
);

    rsu_pkg::t_cmd w_cmd;
    rsu_pkg::t_sts w_sts;

    // unpack the input transfer
    logic [rsu_pkg::SYM_W-1:0]  w_entry_index;
    logic [rsu_pkg::SYM_W-1:0]  w_wiring_letter;
    logic [rsu_pkg::CHAR_W-1:0] w_char_in;
    logic [rsu_pkg::SYM_W-1:0]  w_rotor_position;

    assign w_entry_index    = s_axis_tdata[4:0];
    assign w_wiring_letter  = s_axis_tdata[9:5];
    assign w_char_in        = s_axis_tdata[17:10];
    assign w_rotor_position = s_axis_tdata[22:18];

    // ring setting register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

    // sequencing: accept, shift prep, table lookup or search, output hand-off
    rsu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_op        (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // modular shifts, wiring table and output register
    rsu_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_entry_index    (w_entry_index),
        .i_wiring_letter  (w_wiring_letter),
        .i_char_in        (w_char_in),
        .i_rotor_position (w_rotor_position),
        .o_char_out       (m_axis_tdata)
    );

endmodule

>>> hdl/rsu_checker.sv
// port-level checker of the rotor substitution unit and its bind
`timescale 1ns / 1ps
`include "rotor_substitution_unit_assert.svh"
module rsu_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [rsu_pkg::OP_W-1:0]    s_axis_tuser,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready
);

    logic w_in_xfer;
    logic w_pass_xfer;
    logic w_load_xfer;

    assign w_in_xfer   = s_axis_tvalid && s_axis_tready;
    assign w_pass_xfer = w_in_xfer && (s_axis_tuser == rsu_pkg::OP_FWD ||
                                       s_axis_tuser == rsu_pkg::OP_BWD);
    assign w_load_xfer = w_in_xfer && (s_axis_tuser == rsu_pkg::OP_LOAD);

    // a pending result stays until taken
    `RSU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // a pass item keeps the block busy the next cycle
    `RSU_ASSERT_NEXT(a_pass_busy, w_pass_xfer, !s_axis_tready)
    // a table load leaves the input open
    `RSU_ASSERT_NEXT(a_load_open, w_load_xfer, s_axis_tready)
    // no result right after reset
    `RSU_ASSERT_AFTER_RESET(a_reset_quiet, !m_axis_tvalid)

endmodule

bind rotor_substitution_unit rsu_checker u_rsu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
